// File: design/sbht_pkg.sv
// Package for the segment/box hit test pipeline.
// Widths, register indexes and yaw constants. No dependencies.
package sbht_pkg;

   localparam int CoordW = 24;        // world coordinates
   localparam int ExtW   = 16;        // box extent offsets
   localparam int YawW   = 16;        // heading
   localparam int DeltaW = 25;        // difference of two coordinates
   localparam int DistW  = 26;        // plane distance from the segment start
   localparam int ProdW  = 54;        // exact products plus one divisor term
   localparam int AddrW  = 3;         // csr index

   localparam logic [YawW-1:0] YAW_BIAS = 16'h2000;
   localparam int QuadOddBit = 14;    // bit of (yaw + bias) holding quarter-turn LSB

   typedef enum logic [AddrW-1:0] {
      REG_EXT_X_MIN = 3'd0,
      REG_EXT_X_MAX = 3'd1,
      REG_EXT_Y_MIN = 3'd2,
      REG_EXT_Y_MAX = 3'd3,
      REG_EXT_Z_MIN = 3'd4,
      REG_EXT_Z_MAX = 3'd5
   } csr_index_type;

endpackage

// File: design/segment_box_hit_test.sv
// Segment against yawed box hit test, six-stage pipeline.
// Depends on sbht_pkg (widths, register indexes, yaw constants).
//
// One segment word per cycle enters while the pipeline is not stalled. The six
// register stages are: differences, extents and axis choice, sign
// normalization, the eight 26x26 products, the bound compares, and the output
// register. The plane crossings are never divided out. For a positive divisor
// d, comparing trunc(N/d) with a bound B is done exactly as a compare of N
// against B*d, (B+1)*d or (B-1)*d. The form is picked by the sign of N, so
// truncation toward zero is matched bit for bit. Each stage holds its word while
// the stage after it is full and stalled, so back pressure ripples upward
// without losing anything. The extents sit in csr registers 0..5 (x min/max,
// y min/max, z min/max); writes beyond index five are dropped. The user must
// change them only while idle; the block itself does not enforce it.
module segment_box_hit_test (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_seg_start_x,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_seg_start_y,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_seg_start_z,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_seg_end_x,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_seg_end_y,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_seg_end_z,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_box_x,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_box_y,
   input  logic signed [sbht_pkg::CoordW-1:0]  req_box_z,
   input  logic        [sbht_pkg::YawW-1:0]    req_box_yaw,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   input  logic                                csr_we,
   input  logic        [sbht_pkg::AddrW-1:0]   csr_addr,
   input  logic        [sbht_pkg::ExtW-1:0]    csr_wdata
);

   localparam int DW = sbht_pkg::DeltaW;
   localparam int SW = sbht_pkg::DistW;
   localparam int PW = sbht_pkg::ProdW;
   localparam int EW = sbht_pkg::ExtW;

   // ---------------- extent registers ----------------
   logic signed [EW-1:0] ext_x_min_ff, ext_x_max_ff, ext_y_min_ff;
   logic signed [EW-1:0] ext_y_max_ff, ext_z_min_ff, ext_z_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_min_ff <= '0;
         ext_x_max_ff <= '0;
         ext_y_min_ff <= '0;
         ext_y_max_ff <= '0;
         ext_z_min_ff <= '0;
         ext_z_max_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            sbht_pkg::REG_EXT_X_MIN: ext_x_min_ff <= csr_wdata;
            sbht_pkg::REG_EXT_X_MAX: ext_x_max_ff <= csr_wdata;
            sbht_pkg::REG_EXT_Y_MIN: ext_y_min_ff <= csr_wdata;
            sbht_pkg::REG_EXT_Y_MAX: ext_y_max_ff <= csr_wdata;
            sbht_pkg::REG_EXT_Z_MIN: ext_z_min_ff <= csr_wdata;
            sbht_pkg::REG_EXT_Z_MAX: ext_z_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   assign rdy6 = !v6_ff || rsp_ready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   // ---------------- stage 1: deltas and offsets from segment start ----------------
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic signed [DW-1:0] s1_ox_ff, s1_oy_ff, s1_oz_ff;
   logic                 s1_odd_ff;
   logic [sbht_pkg::YawW-1:0] yaw_sum;

   assign yaw_sum = req_box_yaw + sbht_pkg::YAW_BIAS;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_dx_ff  <= DW'(req_seg_end_x) - DW'(req_seg_start_x);
         s1_dy_ff  <= DW'(req_seg_end_y) - DW'(req_seg_start_y);
         s1_dz_ff  <= DW'(req_seg_end_z) - DW'(req_seg_start_z);
         s1_ox_ff  <= DW'(req_box_x) - DW'(req_seg_start_x);
         s1_oy_ff  <= DW'(req_box_y) - DW'(req_seg_start_y);
         s1_oz_ff  <= DW'(req_box_z) - DW'(req_seg_start_z);
         s1_odd_ff <= yaw_sum[sbht_pkg::QuadOddBit];
      end
   end

   // ---------------- stage 2: swapped extents, plane distances, main axis ----------------
   logic signed [EW-1:0] xa, xb, za, zb;
   logic signed [DW-1:0] adx, adz;
   logic signed [SW-1:0] s2_xlo_ff, s2_xhi_ff, s2_zlo_ff, s2_zhi_ff, s2_ylo_ff, s2_yhi_ff;
   logic signed [DW-1:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic                 s2_zmain_ff, s2_zero_ff;

   always_comb begin
      if (s1_odd_ff) begin
         xa = ext_z_min_ff; xb = ext_z_max_ff;
         za = ext_x_min_ff; zb = ext_x_max_ff;
      end else begin
         xa = ext_x_min_ff; xb = ext_x_max_ff;
         za = ext_z_min_ff; zb = ext_z_max_ff;
      end
      adx = s1_dx_ff[DW-1] ? -s1_dx_ff : s1_dx_ff;
      adz = s1_dz_ff[DW-1] ? -s1_dz_ff : s1_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_xlo_ff   <= SW'(s1_ox_ff) + SW'(xa);
         s2_xhi_ff   <= SW'(s1_ox_ff) + SW'(xb);
         s2_zlo_ff   <= SW'(s1_oz_ff) + SW'(za);
         s2_zhi_ff   <= SW'(s1_oz_ff) + SW'(zb);
         s2_ylo_ff   <= SW'(s1_oy_ff) + SW'(ext_y_min_ff);
         s2_yhi_ff   <= SW'(s1_oy_ff) + SW'(ext_y_max_ff);
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_dz_ff    <= s1_dz_ff;
         // magnitudes fit unsigned in DW bits
         s2_zmain_ff <= $unsigned(adz) > $unsigned(adx);
         s2_zero_ff  <= (s1_dx_ff == '0) && (s1_dz_ff == '0);
      end
   end

   // ---------------- stage 3: axis mux and sign normalization ----------------
   logic signed [SW-1:0] dm, dc, dy_w, mlo, mhi, clo, chi;
   logic                 dm_neg;
   logic signed [SW-1:0] s3_d_ff, s3_dyn_ff, s3_dcn_ff;
   logic signed [SW-1:0] s3_mlo_ff, s3_mhi_ff, s3_ylo_ff, s3_yhi_ff, s3_clo_ff, s3_chi_ff;
   logic                 s3_t0_ff, s3_t1_ff, s3_zero_ff;

   always_comb begin
      dy_w = SW'(s2_dy_ff);
      if (s2_zmain_ff) begin
         dm = SW'(s2_dz_ff); dc = SW'(s2_dx_ff);
         mlo = s2_zlo_ff; mhi = s2_zhi_ff; clo = s2_xlo_ff; chi = s2_xhi_ff;
      end else begin
         dm = SW'(s2_dx_ff); dc = SW'(s2_dz_ff);
         mlo = s2_xlo_ff; mhi = s2_xhi_ff; clo = s2_zlo_ff; chi = s2_zhi_ff;
      end
      dm_neg = dm[SW-1];
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_d_ff    <= dm_neg ? -dm : dm;
         s3_dyn_ff  <= dm_neg ? -dy_w : dy_w;
         s3_dcn_ff  <= dm_neg ? -dc : dc;
         s3_mlo_ff  <= mlo;
         s3_mhi_ff  <= mhi;
         s3_ylo_ff  <= s2_ylo_ff;
         s3_yhi_ff  <= s2_yhi_ff;
         s3_clo_ff  <= clo;
         s3_chi_ff  <= chi;
         // plane is tested when its distance has the delta's sign
         s3_t0_ff   <= mlo[SW-1] == dm_neg;
         s3_t1_ff   <= mhi[SW-1] == dm_neg;
         s3_zero_ff <= s2_zero_ff;
      end
   end

   // ---------------- stage 4: products ----------------
   // full 2*SW-bit signed products, widened to PW afterwards
   logic signed [2*SW-1:0] p_ny0, p_ny1, p_nc0, p_nc1, p_ylo, p_yhi, p_clo, p_chi;
   logic signed [PW-1:0] s4_ny0_ff, s4_ny1_ff, s4_nc0_ff, s4_nc1_ff;
   logic signed [PW-1:0] s4_ylo_ff, s4_yhi_ff, s4_clo_ff, s4_chi_ff, s4_d_ff;
   logic                 s4_t0_ff, s4_t1_ff, s4_zero_ff;

   always_comb begin
      p_ny0 = s3_dyn_ff * s3_mlo_ff;
      p_ny1 = s3_dyn_ff * s3_mhi_ff;
      p_nc0 = s3_dcn_ff * s3_mlo_ff;
      p_nc1 = s3_dcn_ff * s3_mhi_ff;
      p_ylo = s3_ylo_ff * s3_d_ff;
      p_yhi = s3_yhi_ff * s3_d_ff;
      p_clo = s3_clo_ff * s3_d_ff;
      p_chi = s3_chi_ff * s3_d_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_ny0_ff  <= PW'(p_ny0);
         s4_ny1_ff  <= PW'(p_ny1);
         s4_nc0_ff  <= PW'(p_nc0);
         s4_nc1_ff  <= PW'(p_nc1);
         s4_ylo_ff  <= PW'(p_ylo);
         s4_yhi_ff  <= PW'(p_yhi);
         s4_clo_ff  <= PW'(p_clo);
         s4_chi_ff  <= PW'(p_chi);
         s4_d_ff    <= PW'(s3_d_ff);
         s4_t0_ff   <= s3_t0_ff;
         s4_t1_ff   <= s3_t1_ff;
         s4_zero_ff <= s3_zero_ff;
      end
   end

   // ---------------- stage 5: bound compares on the truncated quotients ----------------
   // q = trunc(n/d), d > 0:  q > B  <=> n >= 0 ? n >= B*d + d : n > B*d
   //                         q < B  <=> n >= 0 ? n <  B*d     : n <= B*d - d
   logic y_in0, y_in1, c_lt0, c_lt1, c_gt0, c_gt1;
   logic s5_vy0_ff, s5_vy1_ff, s5_lt0_ff, s5_lt1_ff, s5_gt0_ff, s5_gt1_ff, s5_zero_ff;

   always_comb begin
      y_in0 = (s4_ny0_ff[PW-1] ? (s4_ny0_ff > s4_ylo_ff) : (s4_ny0_ff >= s4_ylo_ff + s4_d_ff))
           && (s4_ny0_ff[PW-1] ? (s4_ny0_ff <= s4_yhi_ff - s4_d_ff) : (s4_ny0_ff < s4_yhi_ff));
      y_in1 = (s4_ny1_ff[PW-1] ? (s4_ny1_ff > s4_ylo_ff) : (s4_ny1_ff >= s4_ylo_ff + s4_d_ff))
           && (s4_ny1_ff[PW-1] ? (s4_ny1_ff <= s4_yhi_ff - s4_d_ff) : (s4_ny1_ff < s4_yhi_ff));
      c_lt0 = s4_nc0_ff[PW-1] ? (s4_nc0_ff <= s4_clo_ff - s4_d_ff) : (s4_nc0_ff < s4_clo_ff);
      c_lt1 = s4_nc1_ff[PW-1] ? (s4_nc1_ff <= s4_clo_ff - s4_d_ff) : (s4_nc1_ff < s4_clo_ff);
      c_gt0 = s4_nc0_ff[PW-1] ? (s4_nc0_ff > s4_chi_ff) : (s4_nc0_ff >= s4_chi_ff + s4_d_ff);
      c_gt1 = s4_nc1_ff[PW-1] ? (s4_nc1_ff > s4_chi_ff) : (s4_nc1_ff >= s4_chi_ff + s4_d_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_vy0_ff  <= s4_t0_ff && y_in0;
         s5_vy1_ff  <= s4_t1_ff && y_in1;
         s5_lt0_ff  <= c_lt0;
         s5_lt1_ff  <= c_lt1;
         s5_gt0_ff  <= c_gt0;
         s5_gt1_ff  <= c_gt1;
         s5_zero_ff <= s4_zero_ff;
      end
   end

   // ---------------- stage 6: combine planes into the hit word ----------------
   logic below, above, inside_any, hit_in;
   logic rsp_hit_ff, rsp_zero_ff;

   always_comb begin
      // below wins over above on one plane, as the min test comes first
      below      = (s5_vy0_ff && s5_lt0_ff) || (s5_vy1_ff && s5_lt1_ff);
      above      = (s5_vy0_ff && !s5_lt0_ff && s5_gt0_ff)
                || (s5_vy1_ff && !s5_lt1_ff && s5_gt1_ff);
      inside_any = (s5_vy0_ff && !s5_lt0_ff && !s5_gt0_ff)
                || (s5_vy1_ff && !s5_lt1_ff && !s5_gt1_ff);
      hit_in     = !s5_zero_ff && (inside_any || (below && above));
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         rsp_hit_ff  <= hit_in;
         rsp_zero_ff <= s5_zero_ff;
      end
   end

   assign rsp_valid = v6_ff;
   assign rsp_hit   = rsp_hit_ff;

`ifndef SYNTHESIS
   a_zero_delta_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_ff |-> !rsp_hit)
      else $error("hit reported for zero horizontal delta");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted word not captured in stage 1");

   a_divisor_positive: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !s4_zero_ff |-> s4_d_ff > 0)
      else $error("normalized divisor not positive");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// File: test/testbench.sv
// Testbench for segment_box_hit_test: directed table then random segment words.
// Depends on sbht_pkg and the segment_box_hit_test RTL; checks against its own predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchLimit = 4000;
   localparam int DrainCycles = 20;
   localparam int CW = sbht_pkg::CoordW;
   localparam int YW = sbht_pkg::YawW;

   typedef struct {
      logic signed [sbht_pkg::CoordW-1:0] sx, sy, sz, ex, ey, ez, bx, by, bz;
      logic [sbht_pkg::YawW-1:0] yaw;
   } seg_word_type;

   // directed row: word plus optional typed-in expectation (-1 = use predictor)
   typedef struct {
      seg_word_type w;
      int known;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [sbht_pkg::CoordW-1:0] req_seg_start_x = 0, req_seg_start_y = 0;
   logic signed [sbht_pkg::CoordW-1:0] req_seg_start_z = 0;
   logic signed [sbht_pkg::CoordW-1:0] req_seg_end_x = 0, req_seg_end_y = 0, req_seg_end_z = 0;
   logic signed [sbht_pkg::CoordW-1:0] req_box_x = 0, req_box_y = 0, req_box_z = 0;
   logic [sbht_pkg::YawW-1:0] req_box_yaw = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_hit;
   logic csr_we = 0;
   logic [sbht_pkg::AddrW-1:0] csr_addr = 0;
   logic [sbht_pkg::ExtW-1:0] csr_wdata = 0;

   segment_box_hit_test dut (.*);

   always #6 clock = ~clock;

   // predictor's own copy of the extent registers
   logic signed [sbht_pkg::ExtW-1:0] extents [6];
   logic expected_hits [$];
   int errors = 0;
   int words_sent = 0, words_checked = 0, hits_seen = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int hold_off = 0;       // long receiver hold-off, counted below
   int quiet = 0;
   bit timed_out = 0;

   task automatic report_mismatch(input string what, input logic got, input logic want);
      $display("mismatch #%0d: %s got %0d expected %0d", words_checked, what, got, want);
      errors++;
   endtask

   // Plane-pair test along the dominant axis; all values relative to start.
   function automatic bit planes_hit(longint dm, longint dy, longint dc, longint mlo,
                                     longint mhi, longint ylo, longint yhi,
                                     longint clo, longint chi);
      bit below, above;
      longint plane_d, yc, cc;
      below = 0;
      above = 0;
      for (int j = 0; j < 2; j++) begin
         plane_d = j ? mhi : mlo;
         if ((plane_d < 0) == (dm < 0)) begin
            yc = (dy * plane_d) / dm;   // SV division truncates toward zero
            if (yc > ylo && yc < yhi) begin
               cc = (dc * plane_d) / dm;
               if (cc < clo) below = 1;
               else if (cc > chi) above = 1;
               else return 1;
            end
         end
      end
      return below && above;
   endfunction

   function automatic logic predict_hit(seg_word_type w);
      longint dx, dy, dz, adx, adz, ylo, yhi, xa, xb, za, zb;
      logic [sbht_pkg::YawW-1:0] turned;
      turned = w.yaw + sbht_pkg::YAW_BIAS;
      dx = longint'(w.ex) - w.sx;
      dy = longint'(w.ey) - w.sy;
      dz = longint'(w.ez) - w.sz;
      adx = dx < 0 ? -dx : dx;
      adz = dz < 0 ? -dz : dz;
      ylo = longint'(w.by) + extents[sbht_pkg::REG_EXT_Y_MIN] - w.sy;
      yhi = longint'(w.by) + extents[sbht_pkg::REG_EXT_Y_MAX] - w.sy;
      // odd quarter-turn swaps the horizontal extents
      if (turned[sbht_pkg::QuadOddBit]) begin
         za = extents[sbht_pkg::REG_EXT_X_MIN]; zb = extents[sbht_pkg::REG_EXT_X_MAX];
         xa = extents[sbht_pkg::REG_EXT_Z_MIN]; xb = extents[sbht_pkg::REG_EXT_Z_MAX];
      end else begin
         za = extents[sbht_pkg::REG_EXT_Z_MIN]; zb = extents[sbht_pkg::REG_EXT_Z_MAX];
         xa = extents[sbht_pkg::REG_EXT_X_MIN]; xb = extents[sbht_pkg::REG_EXT_X_MAX];
      end
      if (dx == 0 && dz == 0) return 0;
      if (adz > adx)
         return planes_hit(dz, dy, dx, w.bz + za - w.sz, w.bz + zb - w.sz, ylo, yhi,
                           w.bx + xa - w.sx, w.bx + xb - w.sx);
      return planes_hit(dx, dy, dz, w.bx + xa - w.sx, w.bx + xb - w.sx, ylo, yhi,
                        w.bz + za - w.sz, w.bz + zb - w.sz);
   endfunction

   // csr write at falling edge; the caller drops the enable
   task automatic write_extent(input sbht_pkg::csr_index_type idx,
                               input logic [sbht_pkg::ExtW-1:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      extents[idx] = val;
   endtask

   task automatic set_extents(input int xlo, xhi, ylo, yhi, zlo, zhi);
      write_extent(sbht_pkg::REG_EXT_X_MIN, xlo[15:0]);
      write_extent(sbht_pkg::REG_EXT_X_MAX, xhi[15:0]);
      write_extent(sbht_pkg::REG_EXT_Y_MIN, ylo[15:0]);
      write_extent(sbht_pkg::REG_EXT_Y_MAX, yhi[15:0]);
      write_extent(sbht_pkg::REG_EXT_Z_MIN, zlo[15:0]);
      write_extent(sbht_pkg::REG_EXT_Z_MAX, zhi[15:0]);
      csr_we <= 0;
   endtask

   // Offer one word: valid drops for an optional random idle gap, then held until taken.
   task automatic send_word(input seg_word_type w, input int known);
      logic want;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_seg_start_x <= w.sx; req_seg_start_y <= w.sy; req_seg_start_z <= w.sz;
      req_seg_end_x <= w.ex; req_seg_end_y <= w.ey; req_seg_end_z <= w.ez;
      req_box_x <= w.bx; req_box_y <= w.by; req_box_z <= w.bz;
      req_box_yaw <= w.yaw;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_hit(w);
      if (known >= 0 && want !== known[0])
         report_mismatch("typed-in expectation vs predictor", want, known[0]);
      expected_hits.push_back(known >= 0 ? known[0] : want);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_empty();
      req_valid <= 0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   function automatic logic signed [sbht_pkg::CoordW-1:0] rand_coord(int span);
      if ($urandom_range(9) == 0) return CW'($urandom);   // full range, all bits
      return CW'($signed($urandom_range(2 * span)) - span);
   endfunction

   // Random word near the box, so hits actually happen.
   function automatic seg_word_type rand_word();
      seg_word_type w;
      int span;
      span = $urandom_range(3) == 0 ? 200000 : 300;
      w.bx = CW'($urandom); w.by = CW'($urandom); w.bz = CW'($urandom);
      if ($urandom_range(3) == 0) begin
         w.bx = rand_coord(2000); w.by = rand_coord(2000); w.bz = rand_coord(2000);
      end
      w.sx = w.bx + rand_coord(span); w.sy = w.by + rand_coord(span);
      w.sz = w.bz + rand_coord(span);
      w.ex = w.bx + rand_coord(span); w.ey = w.by + rand_coord(span);
      w.ez = w.bz + rand_coord(span);
      case ($urandom_range(9))
         0: begin w.ex = w.sx; w.ez = w.sz; end   // vertical-only segment
         1: w.ez = w.sz + (w.ex - w.sx);          // tie between axes
         2: begin                                 // fully random endpoints
            w.sx = CW'($urandom); w.sy = CW'($urandom); w.sz = CW'($urandom);
            w.ex = CW'($urandom); w.ey = CW'($urandom); w.ez = CW'($urandom);
         end
         default: ;
      endcase
      w.yaw = YW'($urandom);
      return w;
   endfunction

   function automatic seg_word_type mk(int sx, sy, sz, ex, ey, ez, bx, by, bz, yaw);
      seg_word_type w;
      w.sx = CW'(sx); w.sy = CW'(sy); w.sz = CW'(sz);
      w.ex = CW'(ex); w.ey = CW'(ey); w.ez = CW'(ez);
      w.bx = CW'(bx); w.by = CW'(by); w.bz = CW'(bz); w.yaw = YW'(yaw);
      return w;
   endfunction

   // Result side: random stall, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   // Checker and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("unexpected hit word", rsp_hit, 1'bx);
            end else begin
               logic want;
               want = expected_hits.pop_front();
               if (rsp_hit !== want) report_mismatch("hit", rsp_hit, want);
               if (rsp_hit === 1'b1) hits_seen++;
            end
            words_checked++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || csr_we) quiet <= 0;
         else quiet <= quiet + 1;
      end
   end

   // Timeout: only the watchdog may end the run early.
   always @(posedge clock) begin
      if (quiet >= WatchLimit + hold_off && !timed_out) begin
         timed_out = 1;
         $display("watchdog: no progress for %0d cycles", quiet);
         $display("TEST FAILED");
         $finish;
      end
   end

   dir_row_type directed [$];

   initial begin
      int phase_pct [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{35, 35}};
      for (int i = 0; i < 6; i++) extents[i] = 0;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // After reset all extents are zero: the box is a point, so nothing hits.
      directed.push_back('{mk(-10, 0, 0, 10, 0, 0, 0, 0, 0, 0), 0});
      directed.push_back('{mk(5, 5, 5, 5, 9, 5, 0, 0, 0, 0), 0});
      recv_stall_pct = 0;
      foreach (directed[i]) send_word(directed[i].w, directed[i].known);
      wait_empty();
      directed.delete();

      // Symmetric box of +-100.
      set_extents(-100, 100, -100, 100, -100, 100);
      directed.push_back('{mk(-500, 0, 0, 500, 0, 0, 0, 0, 0, 0), 1});      // through x
      directed.push_back('{mk(0, 0, -500, 0, 0, 500, 0, 0, 0, 0), 1});      // through z
      directed.push_back('{mk(-500, 500, 0, 500, 500, 0, 0, 0, 0, 0), 0});  // passes above
      directed.push_back('{mk(0, -500, 0, 0, 500, 0, 0, 0, 0, 0), 0});      // zero dx, dz
      directed.push_back('{mk(500, 0, 0, -500, 0, 0, 0, 0, 0, 16'hffff), 1});
      directed.push_back('{mk(-500, 0, -300, 500, 0, 300, 0, 0, 0, 16'h2000), -1});
      directed.push_back('{mk(-500, 0, -500, 500, 0, 500, 0, 0, 0, 16'h6000), -1}); // tie
      directed.push_back('{mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                              -8388608, -8388608, -8388608, 16'h1fff), -1});
      directed.push_back('{mk(-8388608, 0, 8388607, 8388607, 1, -8388608,
                              8388607, 8388607, 8388607, 16'hdfff), -1});
      directed.push_back('{mk(-1000, 100, 0, 1000, 100, 0, 0, 0, 0, 0), 0}); // y on bound
      directed.push_back('{mk(-1000, 0, 100, 1000, 0, 100, 0, 0, 0, 0), 1}); // cross bound
      foreach (directed[i]) send_word(directed[i].w, directed[i].known);
      wait_empty();
      directed.delete();

      // Narrow x, wide z, and inverted extents; yaw swaps them.
      set_extents(-5, 5, -32768, 32767, -3000, 3000);
      directed.push_back('{mk(-500, 0, 0, 500, 0, 0, 0, 0, 0, 16'h4000), -1});
      directed.push_back('{mk(-500, 0, 10, 500, 0, 10, 0, 0, 0, 16'h3fff), -1});
      set_extents(32767, -32768, -32768, 32767, 100, -100);
      directed.push_back('{mk(-50000, 0, 0, 50000, 0, 0, 0, 0, 0, 0), -1});
      directed.push_back('{mk(0, 0, -50000, 1, 0, 50000, 0, 0, 0, 16'h8000), -1});
      foreach (directed[i]) send_word(directed[i].w, directed[i].known);
      wait_empty();

      // Random phases over several extent settings.
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: set_extents(-100, 100, -100, 100, -100, 100);
            1: set_extents($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            2: set_extents(-32768, 32767, -32768, 32767, -32768, 32767);
            default: set_extents(-$urandom_range(300), $urandom_range(300),
                                 -$urandom_range(300), $urandom_range(300),
                                 -$urandom_range(300), $urandom_range(300));
         endcase
         send_idle_pct = phase_pct[p % 4][0];
         recv_stall_pct = phase_pct[p % 4][1];
         for (int i = 0; i < 120; i++) begin
            // long receiver hold-off while words keep coming in
            if (p == 4 && i == 10) hold_off = 300;
            // sender pause until every expected word is back
            if (p == 6 && i == 60) begin
               req_valid <= 0;
               while (expected_hits.size() != 0) @(negedge clock);
            end
            send_word(rand_word(), -1);
         end
         wait_empty();
      end

      $display("covered %0d segment words in %0d phases, %0d hits, %0d checked",
               words_sent, 15, hits_seen, words_checked);
      $display("idle/stall phases, long back-pressure hold-off and extent sweeps done");
      if (errors == 0 && expected_hits.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

// File: files.f
design/sbht_pkg.sv
design/segment_box_hit_test.sv
test/testbench.sv
